// ===== rtl/core/tcw_pkg.sv =====
`default_nettype none

package tcw_pkg;

   // field widths of the request, response and csr channels
   localparam int CHAR_W      = 8;
   localparam int COLOR_W     = 8;
   localparam int CELL_W      = 16;
   localparam int ROW_FIELD_W = 5;
   localparam int COL_FIELD_W = 7;

   localparam int DEF_COLUMNS = 80;
   localparam int DEF_ROWS    = 25;

   localparam logic [CHAR_W-1:0]  NEWLINE_CODE = 8'd10;
   localparam logic [CHAR_W-1:0]  BLANK_CODE   = 8'h20;
   localparam logic [COLOR_W-1:0] RESET_COLOR  = 8'h07;
   localparam logic [CELL_W-1:0]  CLEAR_CELL   = {RESET_COLOR, BLANK_CODE};

   localparam logic REQ_PUT  = 1'b0;
   localparam logic REQ_READ = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FILL,
      ST_RD_ISSUE,
      ST_RESPOND
   } state_type;

endpackage

`default_nettype wire

// ===== rtl/core/text_console_writer.sv =====
// channel | direction | handshake        | payload
// req     | in        | req_valid/stall  | req_type, req_char_code, req_read_row, req_read_col
// rsp     | out       | rsp_valid/stall  | rsp_cell_value, rsp_cursor_row, rsp_cursor_col,
//         |           |                  | rsp_did_scroll
// csr     | in        | csr_valid/ready  | csr_text_color
//
// a put passes IDLE then RESPOND, a read IDLE, RD_ISSUE, RESPOND, a put that scrolls IDLE, FILL,
// RESPOND (one blank write per column); the screen is a single-port-write ram; scrolling moves
// a ring row offset, no copy; after reset the ram is swept to grey blanks, req_stall held high
// a finished response sits in the output register while the next request is taken
// rsp_stall holds the output register and, while it is full, keeps RESPOND waiting; csr writes are taken at any time
`default_nettype none

module text_console_writer #(
   parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
   parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
   input  wire logic                             clock,
   input  wire logic                             reset,

   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic                             req_type,
   input  wire logic [tcw_pkg::CHAR_W-1:0]       req_char_code,
   input  wire logic [tcw_pkg::ROW_FIELD_W-1:0]  req_read_row,
   input  wire logic [tcw_pkg::COL_FIELD_W-1:0]  req_read_col,

   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic      [tcw_pkg::CELL_W-1:0]       rsp_cell_value,
   output logic      [tcw_pkg::ROW_FIELD_W-1:0]  rsp_cursor_row,
   output logic      [tcw_pkg::COL_FIELD_W-1:0]  rsp_cursor_col,
   output logic                                  rsp_did_scroll,

   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [tcw_pkg::COLOR_W-1:0]      csr_text_color
);

   localparam int TOTAL  = ROWS * COLUMNS;
   localparam int AW     = $clog2(TOTAL);
   localparam int AW1    = AW + 1;
   localparam int ROW_W  = $clog2(ROWS);
   localparam int COL_W  = $clog2(COLUMNS);
   localparam int COLP_W = COL_W + 1;

   tcw_pkg::state_type state_ff, state_in;

   logic [AW-1:0]                    clr_addr_ff, clr_addr_in;
   logic [COL_W-1:0]                 fill_col_ff, fill_col_in;
   logic [AW-1:0]                    top_base_ff, top_base_in;
   logic [AW-1:0]                    cur_base_ff, cur_base_in;
   logic [ROW_W-1:0]                 cur_row_ff, cur_row_in;
   logic [COL_W-1:0]                 cur_col_ff, cur_col_in;
   logic [tcw_pkg::COLOR_W-1:0]      color_ff, color_in;
   logic                             scroll_ff, scroll_in;
   logic                             is_read_ff, is_read_in;
   logic                             in_range_ff, in_range_in;
   logic [AW-1:0]                    rd_off_ff, rd_off_in;

   logic                             rsp_valid_ff, rsp_valid_in;
   logic [tcw_pkg::CELL_W-1:0]       rsp_cell_ff, rsp_cell_in;
   logic [tcw_pkg::ROW_FIELD_W-1:0]  rsp_row_ff, rsp_row_in;
   logic [tcw_pkg::COL_FIELD_W-1:0]  rsp_col_ff, rsp_col_in;
   logic                             rsp_scroll_ff, rsp_scroll_in;

   logic                             mem_we, mem_re;
   logic [AW-1:0]                    mem_waddr, mem_raddr;
   logic [tcw_pkg::CELL_W-1:0]       mem_wdata, mem_rdata;

   logic [AW1-1:0]                   top_sum, cur_sum, rd_sum;
   logic [AW-1:0]                    top_next, cur_next;
   logic [COLP_W-1:0]                col_inc;
   logic                             row_last, line_break, slot_free;

   tcw_ram #(
      .WIDTH(tcw_pkg::CELL_W),
      .DEPTH(TOTAL)
   ) u_screen (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // next physical row base, wrapping around the ring
   always_comb begin
      top_sum  = {1'b0, top_base_ff} + AW1'(COLUMNS);
      cur_sum  = {1'b0, cur_base_ff} + AW1'(COLUMNS);
      top_next = (top_sum == AW1'(TOTAL)) ? '0 : top_sum[AW-1:0];
      cur_next = (cur_sum == AW1'(TOTAL)) ? '0 : cur_sum[AW-1:0];
      rd_sum   = {1'b0, top_base_ff} + {1'b0, rd_off_ff};
   end

   assign col_inc   = {1'b0, cur_col_ff} + COLP_W'(1);
   assign row_last  = (cur_row_ff == ROW_W'(ROWS - 1));
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tcw_pkg::ST_CLEAR;
         clr_addr_ff  <= '0;
         top_base_ff  <= '0;
         cur_base_ff  <= '0;
         cur_row_ff   <= '0;
         cur_col_ff   <= '0;
         color_ff     <= tcw_pkg::RESET_COLOR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         top_base_ff  <= top_base_in;
         cur_base_ff  <= cur_base_in;
         cur_row_ff   <= cur_row_in;
         cur_col_ff   <= cur_col_in;
         color_ff     <= color_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fill_col_ff   <= fill_col_in;
      scroll_ff     <= scroll_in;
      is_read_ff    <= is_read_in;
      in_range_ff   <= in_range_in;
      rd_off_ff     <= rd_off_in;
      rsp_cell_ff   <= rsp_cell_in;
      rsp_row_ff    <= rsp_row_in;
      rsp_col_ff    <= rsp_col_in;
      rsp_scroll_ff <= rsp_scroll_in;
   end

   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      fill_col_in   = fill_col_ff;
      top_base_in   = top_base_ff;
      cur_base_in   = cur_base_ff;
      cur_row_in    = cur_row_ff;
      cur_col_in    = cur_col_ff;
      color_in      = (csr_valid && csr_ready) ? csr_text_color : color_ff;
      scroll_in     = scroll_ff;
      is_read_in    = is_read_ff;
      in_range_in   = in_range_ff;
      rd_off_in     = rd_off_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_cell_in   = rsp_cell_ff;
      rsp_row_in    = rsp_row_ff;
      rsp_col_in    = rsp_col_ff;
      rsp_scroll_in = rsp_scroll_ff;
      mem_we        = 1'b0;
      mem_waddr     = cur_base_ff + AW'(cur_col_ff);
      mem_wdata     = {color_ff, req_char_code};
      mem_re        = 1'b0;
      mem_raddr     = rd_sum[AW-1:0];
      line_break    = 1'b0;
      req_stall     = 1'b1;

      unique case (state_ff)
         tcw_pkg::ST_CLEAR: begin
            mem_we      = 1'b1;
            mem_waddr   = clr_addr_ff;
            mem_wdata   = tcw_pkg::CLEAR_CELL;
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_addr_ff == AW'(TOTAL - 1)) begin
               state_in = tcw_pkg::ST_IDLE;
            end
         end

         tcw_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               is_read_in = (req_type == tcw_pkg::REQ_READ);
               scroll_in  = 1'b0;
               if (req_type == tcw_pkg::REQ_READ) begin
                  in_range_in = (32'(req_read_row) < ROWS) && (32'(req_read_col) < COLUMNS);
                  rd_off_in   = AW'(req_read_row) * AW'(COLUMNS) + AW'(req_read_col);
                  state_in    = tcw_pkg::ST_RD_ISSUE;
               end else begin
                  state_in = tcw_pkg::ST_RESPOND;
                  if (req_char_code == tcw_pkg::NEWLINE_CODE) begin
                     line_break = 1'b1;
                  end else begin
                     mem_we = 1'b1;
                     if (col_inc == COLP_W'(COLUMNS)) begin
                        line_break = 1'b1;
                     end else begin
                        cur_col_in = col_inc[COL_W-1:0];
                     end
                  end
                  if (line_break) begin
                     cur_col_in = '0;
                     if (row_last) begin
                        // ring moves down one row; the old top row becomes the bottom
                        scroll_in   = 1'b1;
                        top_base_in = top_next;
                        cur_base_in = top_base_ff;
                        fill_col_in = '0;
                        state_in    = tcw_pkg::ST_FILL;
                     end else begin
                        cur_row_in  = cur_row_ff + ROW_W'(1);
                        cur_base_in = cur_next;
                     end
                  end
               end
            end
         end

         tcw_pkg::ST_FILL: begin
            mem_we      = 1'b1;
            mem_waddr   = cur_base_ff + AW'(fill_col_ff);
            mem_wdata   = {color_ff, tcw_pkg::BLANK_CODE};
            fill_col_in = fill_col_ff + COL_W'(1);
            if (fill_col_ff == COL_W'(COLUMNS - 1)) begin
               state_in = tcw_pkg::ST_RESPOND;
            end
         end

         tcw_pkg::ST_RD_ISSUE: begin
            mem_re = in_range_ff;
            if (rd_sum >= AW1'(TOTAL)) begin
               mem_raddr = AW'(rd_sum - AW1'(TOTAL));
            end
            state_in = tcw_pkg::ST_RESPOND;
         end

         tcw_pkg::ST_RESPOND: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_cell_in   = (is_read_ff && in_range_ff) ? mem_rdata : '0;
               rsp_row_in    = tcw_pkg::ROW_FIELD_W'(cur_row_ff);
               rsp_col_in    = tcw_pkg::COL_FIELD_W'(cur_col_ff);
               rsp_scroll_in = scroll_ff;
               state_in      = tcw_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = tcw_pkg::ST_IDLE;
         end
      endcase
   end

   assign csr_ready      = 1'b1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_value = rsp_cell_ff;
   assign rsp_cursor_row = rsp_row_ff;
   assign rsp_cursor_col = rsp_col_ff;
   assign rsp_did_scroll = rsp_scroll_ff;

`ifndef SYNTH
   // a scroll leaves the cursor at the start of the last row
   a_scroll_cursor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_did_scroll |->
         rsp_cell_value == '0 && rsp_cursor_col == '0 &&
         rsp_cursor_row == tcw_pkg::ROW_FIELD_W'(ROWS - 1))
      else $error("scroll response with wrong cursor or cell");

   // a put that breaks the last line starts the blank fill
   a_fill_start: assert property (@(posedge clock) disable iff (reset)
      state_ff == tcw_pkg::ST_IDLE && req_valid && req_type == tcw_pkg::REQ_PUT &&
      row_last && (req_char_code == tcw_pkg::NEWLINE_CODE ||
                   cur_col_ff == COL_W'(COLUMNS - 1))
      |=> state_ff == tcw_pkg::ST_FILL)
      else $error("scroll did not start a row fill");

   a_waddr_range: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> 32'(mem_waddr) < TOTAL && 32'(cur_base_ff) < TOTAL)
      else $error("screen write address out of range");

   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      state_ff == tcw_pkg::ST_CLEAR |-> req_stall && !rsp_valid)
      else $error("transfer during screen clear");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/tcw_ram.sv =====
`default_nettype none

module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== verif/text_console_writer_test.sv =====
module text_console_writer_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SCR_COLS      = tcw_pkg::DEF_COLUMNS;
   localparam int SCR_ROWS      = tcw_pkg::DEF_ROWS;
   localparam int HOLD_CYCLES   = 400;
   localparam int QUIET_LIMIT   = 20000;
   localparam int SETTLE_CYCLES = 2 * SCR_COLS + 20;
   localparam int RANDOM_PHASES = 7;
   localparam int PHASE_ITEMS   = 200;

   typedef struct packed {
      logic [tcw_pkg::CELL_W-1:0]      cell_val;
      logic [tcw_pkg::ROW_FIELD_W-1:0] row;
      logic [tcw_pkg::COL_FIELD_W-1:0] col;
      logic                            scrolled;
   } console_rsp_type;

   logic                            clock          = 1'b0;
   logic                            reset          = 1'b1;
   logic                            req_valid      = 1'b0;
   logic                            req_stall;
   logic                            req_type       = tcw_pkg::REQ_PUT;
   logic [tcw_pkg::CHAR_W-1:0]      req_char_code  = '0;
   logic [tcw_pkg::ROW_FIELD_W-1:0] req_read_row   = '0;
   logic [tcw_pkg::COL_FIELD_W-1:0] req_read_col   = '0;
   logic                            rsp_valid;
   logic                            rsp_stall      = 1'b0;
   logic [tcw_pkg::CELL_W-1:0]      rsp_cell_value;
   logic [tcw_pkg::ROW_FIELD_W-1:0] rsp_cursor_row;
   logic [tcw_pkg::COL_FIELD_W-1:0] rsp_cursor_col;
   logic                            rsp_did_scroll;
   logic                            csr_valid      = 1'b0;
   logic                            csr_ready;
   logic [tcw_pkg::COLOR_W-1:0]     csr_text_color = '0;

   // screen as the block should hold it, without the ring offset
   logic [tcw_pkg::CELL_W-1:0]  screen_model [SCR_ROWS*SCR_COLS];
   int unsigned                 crsr_row;
   int unsigned                 crsr_col;
   logic [tcw_pkg::COLOR_W-1:0] color_model;
   console_rsp_type             awaited_rsp [$];
   int unsigned                 mismatches = 0;

   // sender and receiver pacing
   int unsigned gap_max    = 0;
   int unsigned burst_max  = 1;
   int unsigned burst_left = 0;
   int unsigned stall_pct  = 0;
   int unsigned stall_run  = 0;
   logic        stall_on   = 1'b0;
   int unsigned hold_reqs  = 0;
   int unsigned hold_seen  = 0;
   int unsigned hold_left  = 0;
   int unsigned quiet_cycles = 0;

   text_console_writer u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_char_code  (req_char_code),
      .req_read_row   (req_read_row),
      .req_read_col   (req_read_col),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_cell_value (rsp_cell_value),
      .rsp_cursor_row (rsp_cursor_row),
      .rsp_cursor_col (rsp_cursor_col),
      .rsp_did_scroll (rsp_did_scroll),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_text_color (csr_text_color)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic console_rsp_type predict_console(int unsigned kind, int unsigned ch,
         int unsigned rr, int unsigned rc);
      console_rsp_type res;
      res = '0;
      if (kind[0] == tcw_pkg::REQ_READ) begin
         if (rr < SCR_ROWS && rc < SCR_COLS) res.cell_val = screen_model[rr*SCR_COLS + rc];
      end else begin
         if (ch[tcw_pkg::CHAR_W-1:0] != tcw_pkg::NEWLINE_CODE) begin
            screen_model[crsr_row*SCR_COLS + crsr_col] =
               {color_model, ch[tcw_pkg::CHAR_W-1:0]};
            crsr_col++;
         end
         if (ch[tcw_pkg::CHAR_W-1:0] == tcw_pkg::NEWLINE_CODE || crsr_col >= SCR_COLS) begin
            crsr_col = 0;
            crsr_row++;
            if (crsr_row >= SCR_ROWS) begin
               crsr_row = SCR_ROWS - 1;
               for (int i = 0; i < (SCR_ROWS-1)*SCR_COLS; i++)
                  screen_model[i] = screen_model[i+SCR_COLS];
               for (int i = 0; i < SCR_COLS; i++)
                  screen_model[(SCR_ROWS-1)*SCR_COLS + i] =
                     {color_model, tcw_pkg::BLANK_CODE};
               res.scrolled = 1'b1;
            end
         end
      end
      res.row = crsr_row[tcw_pkg::ROW_FIELD_W-1:0];
      res.col = crsr_col[tcw_pkg::COL_FIELD_W-1:0];
      return res;
   endfunction

   task automatic send_req(int unsigned kind, int unsigned ch, int unsigned rr,
         int unsigned rc);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = $urandom_range(gap_max);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(burst_max, 1);
      end
      req_valid     <= 1'b1;
      req_type      <= kind[0];
      req_char_code <= ch[tcw_pkg::CHAR_W-1:0];
      req_read_row  <= rr[tcw_pkg::ROW_FIELD_W-1:0];
      req_read_col  <= rc[tcw_pkg::COL_FIELD_W-1:0];
      do @(posedge clock); while (req_stall);
      awaited_rsp.push_back(predict_console(kind, ch, rr, rc));
      burst_left--;
   endtask

   // the unused fields of each kind carry noise
   task automatic put_char(int unsigned ch);
      send_req(tcw_pkg::REQ_PUT, ch, $urandom_range(31), $urandom_range(127));
   endtask

   task automatic read_cell(int unsigned rr, int unsigned rc);
      send_req(tcw_pkg::REQ_READ, $urandom_range(255), rr, rc);
   endtask

   task automatic drain_rsp();
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (awaited_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic write_color(int unsigned value);
      csr_valid      <= 1'b1;
      csr_text_color <= value[tcw_pkg::COLOR_W-1:0];
      do @(posedge clock); while (!csr_ready);
      color_model = value[tcw_pkg::COLOR_W-1:0];
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_pacing(int unsigned gmax, int unsigned bmax, int unsigned spct);
      gap_max   = gmax;
      burst_max = bmax;
      stall_pct = spct;
   endtask

   task automatic send_random_item();
      int unsigned pick;
      int unsigned rr;
      pick = $urandom_range(99);
      if (pick < 10) begin
         send_req($urandom_range(1), $urandom_range(255), $urandom_range(31),
                  $urandom_range(127));
      end else if (pick < 35) begin
         // mostly look at what was just typed
         rr = (crsr_row > 0 && $urandom_range(1) == 1) ? crsr_row - 1 : crsr_row;
         read_cell(rr, $urandom_range(SCR_COLS-1));
      end else if (pick < 40) begin
         read_cell($urandom_range(SCR_ROWS-1), $urandom_range(SCR_COLS-1));
      end else if (pick < 47) begin
         put_char(tcw_pkg::NEWLINE_CODE);
      end else begin
         put_char($urandom_range(255));
      end
   endtask

   task automatic test_directed();
      set_pacing(0, 8, 0);
      read_cell(0, 0);
      read_cell(SCR_ROWS-1, SCR_COLS-1);
      read_cell(SCR_ROWS, 0);
      read_cell(0, SCR_COLS);
      read_cell(31, 127);
      read_cell(SCR_ROWS-1, 0);
      put_char(8'h00);
      put_char(8'hFF);
      put_char(8'h41);
      put_char(tcw_pkg::NEWLINE_CODE);
      put_char(tcw_pkg::NEWLINE_CODE);
      put_char(8'h7F);
      read_cell(0, 0);
      read_cell(0, 1);
      read_cell(0, 2);
      read_cell(0, 3);
      read_cell(1, 0);
      read_cell(2, 0);
      read_cell(2, 1);
      drain_rsp();
   endtask

   task automatic test_color_extremes();
      logic [tcw_pkg::COLOR_W-1:0] shades [4] = '{8'h00, 8'hFF, 8'hA5, 8'h5A};
      int unsigned rr;
      int unsigned rc;
      set_pacing(1, 4, 20);
      foreach (shades[k]) begin
         drain_rsp();
         write_color(shades[k]);
         rr = crsr_row;
         rc = crsr_col;
         put_char($urandom_range(255, 11));
         read_cell(rr, rc);
      end
      put_char(tcw_pkg::NEWLINE_CODE);
      drain_rsp();
   endtask

   task automatic test_wrap_and_scroll();
      set_pacing(3, 8, 30);
      write_color($urandom_range(255));
      put_char(tcw_pkg::NEWLINE_CODE);
      // a full line wraps on its own
      for (int i = 0; i < SCR_COLS; i++) put_char(8'h21 + i);
      for (int i = 0; i < 4; i++) read_cell(crsr_row - 1, $urandom_range(SCR_COLS-1));
      // walk past the bottom so several scrolls happen
      for (int i = 0; i < SCR_ROWS + 5; i++) put_char(tcw_pkg::NEWLINE_CODE);
      for (int i = 0; i < 4; i++) read_cell(SCR_ROWS-1, $urandom_range(SCR_COLS-1));
      read_cell(0, 0);
      drain_rsp();
      write_color($urandom_range(255));
      for (int i = 0; i < 3 * SCR_COLS; i++) begin
         if ($urandom_range(9) == 0) read_cell(crsr_row - 1, $urandom_range(SCR_COLS-1));
         else put_char($urandom_range(255, 11));
      end
      drain_rsp();
   endtask

   task automatic test_random_traffic();
      int unsigned pace [RANDOM_PHASES][3] = '{
         '{0, 16, 0}, '{2, 4, 20}, '{6, 2, 50}, '{1, 20, 10},
         '{10, 6, 70}, '{0, 8, 90}, '{4, 10, 35}};
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         drain_rsp();
         if (p == 0) write_color(8'h00);
         else if (p == 1) write_color(8'hFF);
         else write_color($urandom_range(255));
         set_pacing(pace[p][0], pace[p][1], pace[p][2]);
         for (int i = 0; i < PHASE_ITEMS; i++) send_random_item();
      end
      drain_rsp();
   endtask

   // receiver holds off while the sender keeps offering, so the input backs up
   task automatic test_output_backpressure();
      set_pacing(0, 32, 0);
      hold_reqs <= hold_reqs + 1;
      for (int i = 0; i < 60; i++) send_random_item();
      drain_rsp();
   endtask

   task automatic test_paused_sender();
      set_pacing(1, 4, 25);
      for (int b = 0; b < 20; b++) begin
         for (int i = 0; i < 5; i++) send_random_item();
         drain_rsp();
      end
   endtask

   always @(posedge clock) begin
      if (hold_seen != hold_reqs) begin
         hold_seen = hold_reqs;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         if (stall_run == 0) begin
            stall_run = $urandom_range(6, 1);
            stall_on  = $urandom_range(99) < stall_pct;
         end
         stall_run--;
         rsp_stall <= stall_on;
      end
   end

   always @(posedge clock) begin
      console_rsp_type want;
      console_rsp_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_cell_value, rsp_cursor_row, rsp_cursor_col, rsp_did_scroll};
         if (awaited_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected transfer: cell %h row %0d col %0d scroll %b",
                        got.cell_val, got.row, got.col, got.scrolled);
         end else begin
            want = awaited_rsp.pop_front();
            if (got.cell_val !== want.cell_val || got.row !== want.row ||
                got.col !== want.col || got.scrolled !== want.scrolled) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected cell %h row %0d col %0d scroll %b, %s",
                           want.cell_val, want.row, want.col, want.scrolled,
                           $sformatf("got cell %h row %0d col %0d scroll %b",
                                     got.cell_val, got.row, got.col, got.scrolled));
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      for (int i = 0; i < SCR_ROWS*SCR_COLS; i++) screen_model[i] = tcw_pkg::CLEAR_CELL;
      color_model = tcw_pkg::RESET_COLOR;
      crsr_row    = 0;
      crsr_col    = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_color_extremes();
      test_wrap_and_scroll();
      test_random_traffic();
      test_output_backpressure();
      test_paused_sender();

      drain_rsp();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && awaited_rsp.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
